[hw/rtl/mts_pkg.sv]
// ----------------------------------------------------------------------------
// mts_pkg: shared types and tables for the markup tag / entity stripper
// Scan modes, entity trie steps and the literal text held at each trie node.
// ----------------------------------------------------------------------------
`default_nettype none

package mts_pkg;

  localparam int MaxResults = 6;
  localparam int CntW       = 3;   // holds 0..MaxResults
  localparam int NodeW      = 4;

  typedef enum logic [2:0] {
    MODE_TEXT = 3'd0,
    MODE_LT   = 3'd1,
    MODE_LT_B = 3'd2,
    MODE_TAG  = 3'd3
  } mode_t;

  localparam logic [NodeW-1:0] NODE_NONE = 4'd0;
  localparam logic [NodeW-1:0] NODE_AMP  = 4'd1;

  // Trie step for the entity names; zero means the byte does not continue.
  function automatic logic [NodeW-1:0] trie_step(input logic [NodeW-1:0] node,
                                                 input logic [7:0] b);
    logic [NodeW-1:0] nxt;
    nxt = NODE_NONE;
    case (node)
      4'd1: begin
        case (b)
          "a":     nxt = 4'd2;
          "l":     nxt = 4'd5;
          "g":     nxt = 4'd7;
          "q":     nxt = 4'd9;
          "#":     nxt = 4'd13;
          default: nxt = NODE_NONE;
        endcase
      end
      4'd2:    nxt = (b == "m") ? 4'd3  : NODE_NONE;
      4'd3:    nxt = (b == "p") ? 4'd4  : NODE_NONE;
      4'd5:    nxt = (b == "t") ? 4'd6  : NODE_NONE;
      4'd7:    nxt = (b == "t") ? 4'd8  : NODE_NONE;
      4'd9:    nxt = (b == "u") ? 4'd10 : NODE_NONE;
      4'd10:   nxt = (b == "o") ? 4'd11 : NODE_NONE;
      4'd11:   nxt = (b == "t") ? 4'd12 : NODE_NONE;
      4'd13:   nxt = (b == "3") ? 4'd14 : NODE_NONE;
      4'd14:   nxt = (b == "9") ? 4'd15 : NODE_NONE;
      default: nxt = NODE_NONE;
    endcase
    return nxt;
  endfunction

  // Character a ';' decodes to at a complete entity node, zero elsewhere.
  function automatic logic [7:0] decoded_char(input logic [NodeW-1:0] node);
    logic [7:0] c;
    case (node)
      4'd4:    c = "&";
      4'd6:    c = "<";
      4'd8:    c = ">";
      4'd12:   c = 8'h22;
      4'd15:   c = 8'h27;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] held_len(input logic [NodeW-1:0] node);
    logic [2:0] n;
    case (node)
      4'd1:                       n = 3'd1;
      4'd2, 4'd5, 4'd7, 4'd9,
      4'd13:                      n = 3'd2;
      4'd3, 4'd6, 4'd8, 4'd10,
      4'd14:                      n = 3'd3;
      4'd4, 4'd11, 4'd15:         n = 3'd4;
      4'd12:                      n = 3'd5;
      default:                    n = 3'd0;
    endcase
    return n;
  endfunction

  // Literal text held at a node, first character in the top byte.
  function automatic logic [39:0] held_text(input logic [NodeW-1:0] node);
    logic [39:0] t;
    case (node)
      4'd1:    t = {"&",    32'h0};
      4'd2:    t = {"&a",   24'h0};
      4'd3:    t = {"&am",  16'h0};
      4'd4:    t = {"&amp",  8'h0};
      4'd5:    t = {"&l",   24'h0};
      4'd6:    t = {"&lt",  16'h0};
      4'd7:    t = {"&g",   24'h0};
      4'd8:    t = {"&gt",  16'h0};
      4'd9:    t = {"&q",   24'h0};
      4'd10:   t = {"&qu",  16'h0};
      4'd11:   t = {"&quo",  8'h0};
      4'd12:   t = "&quot";
      4'd13:   t = {"&#",   24'h0};
      4'd14:   t = {"&#3",  16'h0};
      4'd15:   t = {"&#39",  8'h0};
      default: t = 40'h0;
    endcase
    return t;
  endfunction

  function automatic logic [7:0] held_char(input logic [NodeW-1:0] node,
                                           input logic [2:0] idx);
    logic [39:0] t;
    logic [7:0]  c;
    t = held_text(node);
    case (idx)
      3'd0:    c = t[39:32];
      3'd1:    c = t[31:24];
      3'd2:    c = t[23:16];
      3'd3:    c = t[15:8];
      3'd4:    c = t[7:0];
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/markup_tag_entity_stripper.sv]
// ----------------------------------------------------------------------------
// markup_tag_entity_stripper: strips markup tags and decodes basic entities
// One text byte per transaction in, zero to six result bytes out.
// ----------------------------------------------------------------------------
//  channel  handshake             payload
//  in       in_valid / in_ready   in_byte, in_last
//  out      out_valid / out_ready out_byte, has_byte, run_last, stream_end
//
//  An input transaction is decoded in the cycle it is accepted and its results
//  are loaded into a six-slot result register, drained one per cycle while
//  out_ready is high. A new byte is taken when the result register is empty
//  or its last entry leaves in the same cycle: one byte per cycle while each
//  makes <= 1 result. A byte flushing a held entity prefix stalls input until
//  its extra results drain. Reset (synchronous) clears scan state and results.
// ----------------------------------------------------------------------------
`default_nettype none

module markup_tag_entity_stripper (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       has_byte,
  output logic       run_last,
  output logic       stream_end
);
  import mts_pkg::*;

  mode_t            mode, mode_next;
  logic [NodeW-1:0] node, node_next;

  logic [7:0]       slot_byte [MaxResults];
  logic [7:0]       slot_next [MaxResults];
  logic [CntW-1:0]  cnt, cnt_next;
  logic             slot_hb, hb_next;
  logic             slot_end;

  logic             in_take, out_take;
  logic [NodeW-1:0] flush1, flush2, step;
  logic             emit;
  logic [7:0]       emit_ch;
  logic [2:0]       len1, len2;
  logic [3:0]       total;

  assign in_take  = in_valid && in_ready;
  assign out_take = out_valid && out_ready;
  assign in_ready = (cnt == '0) || ((cnt == CntW'(1)) && out_ready);

  // Scan one byte: tag tracking and entity trie
  always_comb begin
    mode_next = mode;
    node_next = node;
    flush1    = NODE_NONE;
    emit      = 1'b0;
    emit_ch   = in_byte;
    step      = trie_step(node, in_byte);
    case (mode)
      MODE_LT: begin
        if (in_byte == ">") mode_next = MODE_TEXT;
        else if (in_byte inside {"b", "B"}) mode_next = MODE_LT_B;
        else mode_next = MODE_TAG;
      end
      MODE_LT_B: begin
        if (in_byte == ">") begin
          mode_next = MODE_TEXT;
        end else begin
          mode_next = MODE_TAG;
          if (in_byte inside {"r", "R"}) begin
            emit    = 1'b1;
            emit_ch = 8'h0a;
          end
        end
      end
      MODE_TAG: begin
        if (in_byte == ">") mode_next = MODE_TEXT;
      end
      default: begin
        mode_next = MODE_TEXT;
        if (node != NODE_NONE && step != NODE_NONE) begin
          node_next = step;
        end else if (node != NODE_NONE && in_byte == ";" &&
                     decoded_char(node) != 8'h00) begin
          emit      = 1'b1;
          emit_ch   = decoded_char(node);
          node_next = NODE_NONE;
        end else begin
          // prefix did not continue: held text goes out literally first
          flush1    = node;
          node_next = NODE_NONE;
          if (in_byte == "<") mode_next = MODE_LT;
          else if (in_byte == "&") node_next = NODE_AMP;
          else emit = 1'b1;
        end
      end
    endcase
    flush2 = NODE_NONE;
    if (in_last) begin
      flush2    = node_next;
      node_next = NODE_NONE;
      mode_next = MODE_TEXT;
    end
  end

  // Lay out the results of this byte into the slots
  always_comb begin
    len1  = held_len(flush1);
    len2  = held_len(flush2);
    total = 4'(len1) + 4'(emit) + 4'(len2);
    for (int k = 0; k < MaxResults; k++) begin
      if (4'(k) < 4'(len1)) slot_next[k] = held_char(flush1, 3'(k));
      else if (emit && 4'(k) == 4'(len1)) slot_next[k] = emit_ch;
      else slot_next[k] = held_char(flush2, 3'(4'(k) - 4'(len1) - 4'(emit)));
    end
    hb_next = 1'b1;
    if (total > 4'(MaxResults)) begin
      cnt_next = CntW'(MaxResults);
    end else if (total == 4'd0 && in_last) begin
      cnt_next = CntW'(1);     // end marker with no byte
      hb_next  = 1'b0;
    end else begin
      cnt_next = total[CntW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_TEXT;
      node <= NODE_NONE;
      cnt  <= '0;
    end else if (in_take) begin
      mode <= mode_next;
      node <= node_next;
      cnt  <= cnt_next;
    end else if (out_take) begin
      cnt <= cnt - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      slot_byte <= slot_next;
      slot_hb   <= hb_next;
      slot_end  <= in_last;
    end else if (out_take) begin
      for (int k = 0; k < MaxResults - 1; k++) slot_byte[k] <= slot_byte[k+1];
    end
  end

  assign out_valid  = (cnt != '0);
  assign out_byte   = slot_byte[0];
  assign has_byte   = slot_hb;
  assign run_last   = (cnt == CntW'(1));
  assign stream_end = slot_end;

`ifndef SYNTH
  a_take_only_when_drained: assert property (@(posedge clk) disable iff (rst)
    in_take |-> (cnt <= CntW'(1)))
    else $error("input taken while results still pending");

  a_last_resets_scan: assert property (@(posedge clk) disable iff (rst)
    (in_take && in_last) |=> (mode == MODE_TEXT && node == NODE_NONE))
    else $error("scan state not cleared after final byte");

  a_marker_is_final: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !has_byte) |-> (run_last && stream_end && out_byte == 8'h00))
    else $error("end marker without run_last/stream_end");
`endif

endmodule

`default_nettype wire
